/* design/efbd_pkg.sv */
// Package for the escape-framed byte deframer.
// Shared sizes, register indexes, command and state types; no dependencies.
`default_nettype none

package efbd_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int FILL_W          = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W          = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 1'd1;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h48;
  localparam logic [BYTE_W-1:0] START_RESET  = 8'h10;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_HUNT_ESC,
    MODE_FRAME,
    MODE_FRAME_ESC
  } mode_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_STORE,
    CMD_CLOSE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic {
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

endpackage

`default_nettype wire

/* design/efbd_front.sv */
// Front end: holds the code registers, parses the byte stream and pushes
// store, clear and close commands. Depends on efbd_pkg.
`default_nettype none

module efbd_front
  import efbd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BYTE_W-1:0]    in_tdata,
  input  wire queue_status_t        q_status,
  output logic                      q_push,
  output cmd_t                      q_cmd
);

  logic [BYTE_W-1:0] escape_r;
  logic [BYTE_W-1:0] start_r;
  mode_t             mode_r;
  mode_t             mode_nxt;
  logic              accept;
  logic              is_esc;
  logic              is_start;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign is_esc    = (in_tdata == escape_r);
  assign is_start  = (in_tdata == start_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= ESCAPE_RESET;
      start_r  <= START_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ESCAPE) begin
        escape_r <= cfg_wdata;
      end
      if (cfg_index == REG_START) begin
        start_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      case (mode_r)
        MODE_HUNT: begin
          if (is_esc) mode_nxt = MODE_HUNT_ESC;
        end
        MODE_HUNT_ESC: begin
          mode_nxt = is_start ? MODE_FRAME : MODE_HUNT;
        end
        MODE_FRAME: begin
          if (is_esc) mode_nxt = MODE_FRAME_ESC;
        end
        MODE_FRAME_ESC: begin
          if (is_start) mode_nxt = MODE_HUNT;
          else if (is_esc) mode_nxt = MODE_FRAME;
          else mode_nxt = MODE_HUNT;
        end
        default: mode_nxt = MODE_HUNT;
      endcase
    end
  end

  always_comb begin
    q_push      = 1'b0;
    q_cmd.kind  = CMD_STORE;
    q_cmd.data  = in_tdata;
    case (mode_r)
      MODE_HUNT: begin
        q_push = 1'b0;
      end
      MODE_HUNT_ESC: begin
        q_push     = accept && is_start;
        q_cmd.kind = CMD_CLEAR;
      end
      MODE_FRAME: begin
        q_push     = accept && !is_esc;
        q_cmd.kind = CMD_STORE;
      end
      MODE_FRAME_ESC: begin
        q_push = accept;
        if (is_start) q_cmd.kind = CMD_CLOSE;
        else if (is_esc) q_cmd.kind = CMD_STORE;
        else q_cmd.kind = CMD_CLEAR;
      end
      default: q_push = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* design/efbd_cmd_fifo.sv */
// Short command queue between the parser and the frame back end.
// Depends on efbd_pkg.
`default_nettype none

module efbd_cmd_fifo
  import efbd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire cmd_t    push_cmd,
  input  wire logic    pop,
  output cmd_t         head_cmd,
  output queue_status_t status
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head_cmd     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/efbd_back.sv */
// Back end: executes queued commands on the frame buffer and drains a
// closed frame through a registered read and an output register. Depends on efbd_pkg.
`default_nettype none

module efbd_back
  import efbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  logic [BYTE_W-1:0] frame_mem [MAX_FRAME_BYTES];

  bk_state_t         state_r;
  bk_state_t         state_nxt;
  logic [FILL_W-1:0] fill_r;
  logic              ovf_r;
  logic [ADDR_W-1:0] idx_r;

  logic              rd_valid_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_last_r;
  logic              rd_trunc_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;
  logic              out_trunc_r;

  logic              advance;
  logic              issue;
  logic              issue_last;
  logic              room;

  assign advance    = !out_valid_r || out_tready;
  assign issue_last = (FILL_W'(idx_r) == fill_r - FILL_W'(1));
  assign room       = (fill_r < FILL_W'(MAX_FRAME_BYTES));

  always_comb begin
    cmd_pop = 1'b0;
    issue   = 1'b0;
    case (state_r)
      BK_RUN:   cmd_pop = cmd_valid;
      BK_DRAIN: issue   = !rd_valid_r || advance;
      default: begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (cmd_pop && cmd.kind == CMD_CLOSE && fill_r != '0) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (issue && issue_last) state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd_pop) begin
        case (cmd.kind)
          CMD_STORE: begin
            if (room) fill_r <= fill_r + FILL_W'(1);
            else ovf_r <= 1'b1;
          end
          CMD_CLOSE: begin
            idx_r <= '0;
            if (fill_r == '0) ovf_r <= 1'b0;
          end
          default: begin
            fill_r <= '0;
            ovf_r  <= 1'b0;
          end
        endcase
      end
      if (issue) begin
        idx_r <= idx_r + ADDR_W'(1);
        if (issue_last) begin
          fill_r <= '0;
          ovf_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_STORE && room) begin
      frame_mem[fill_r[ADDR_W-1:0]] <= cmd.data;
    end
    if (issue) begin
      rd_data_r  <= frame_mem[idx_r];
      rd_last_r  <= issue_last;
      rd_trunc_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) rd_valid_r <= 1'b1;
      else if (advance) rd_valid_r <= 1'b0;
      if (advance) out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r  <= rd_data_r;
      out_last_r  <= rd_last_r;
      out_trunc_r <= rd_trunc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_trunc_r;

endmodule

`default_nettype wire

/* design/escape_framed_byte_deframer_top.sv */
// Top level of the escape-framed byte deframer.
// Instantiates efbd_front, efbd_cmd_fifo and efbd_back; uses efbd_pkg.
//
// The block takes one received byte per cycle while the command queue has
// room and hunts for escape followed by start to open a frame; escape-escape
// stores one escape, escape-start closes the frame, any other byte after an
// escape drops it. A closed frame leaves on the output stream at one byte
// per cycle while out_tready is high, paced by the single read port of the
// 64-byte frame buffer; its close command passes through the command queue,
// and the first byte then leaves through the registered read and the output
// register. While a frame drains, the parser keeps accepting bytes until
// the four-entry command queue is full, so when the next frame follows at
// once, input stalls until the frame has drained. Empty frames emit nothing;
// bytes beyond 64 are dropped and every byte of that frame carries the
// truncated flag. No clearing pass is needed after reset.
`default_nettype none

module escape_framed_byte_deframer_top
  import efbd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [BYTE_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [BYTE_W-1:0]         out_tdata,  // [7:0] frame_byte
  output logic                      out_tlast,
  output logic                      out_tuser   // [0] frame_truncated
);

  queue_status_t q_status;
  logic          q_push;
  cmd_t          q_cmd;
  cmd_t          head_cmd;
  logic          cmd_pop;

  efbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  efbd_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  efbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_status.valid),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* design/efbd_checker.sv */
// Port-level checks for the deframer top level, with the bind that attaches them.
// Depends on efbd_pkg.
`default_nettype none

module efbd_port_checks
  import efbd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [BYTE_W-1:0]    out_tdata,
  input wire logic                 out_tlast,
  input wire logic                 out_tuser
);

  a_reset_quiet : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output changed");

  a_trunc_per_frame : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(out_tvalid && out_tready && !out_tlast)
      |-> out_tuser == $past(out_tuser))
    else $error("truncated flag changed inside a frame");

endmodule

bind escape_framed_byte_deframer_top efbd_port_checks u_port_checks (.*);

`default_nettype wire
